// ===== sv/vppc_pkg.sv =====
`default_nettype none
package vppc_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_INDEX = 1'b1;

	localparam logic [7:0] PRIO_NONE = 8'hFF;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic        entry_enabled;
		logic [15:0] outer_vlan;
		logic [15:0] outer_mask;
		logic [15:0] inner_vlan;
		logic [15:0] inner_mask;
		logic [15:0] interface_req;
		logic [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [3:0] profile_index;
		logic       used_default;
	} res_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic write;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic last;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ===== sv/vppc_ctrl.sv =====
`default_nettype none
module vppc_ctrl import vppc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     op,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd,
	output logic          busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WRITE = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (op == OP_WRITE) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_WRITE: begin
				cmd.write  = 1'b1;
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.last) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/vppc_dp.sv =====
`default_nettype none
module vppc_dp import vppc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire req_t                  req,
	input  wire ctl_cmd_t              cmd,
	output ctl_sts_t                   sts,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                       done,
	output res_t                       res
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic [15:0] ov;
		logic [15:0] om;
		logic [15:0] iv;
		logic [15:0] im;
		logic        en;
		logic [7:0]  prio;
		logic [15:0] itf;
	} rule_t;

	rule_t             mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	req_t             req_q;
	logic [IDX_W-1:0] cnt_q;
	rule_t            rule_s1;
	logic             vld_s1;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             found_q;
	logic [7:0]       best_prio_q;
	logic [IDX_W-1:0] best_idx_q;

	logic       def_valid_q;
	logic [3:0] def_index_q;

	logic             done_q;
	res_t             res_q;

	logic [8:0]       w_wide;
	logic [8:0]       d_wide;
	logic [8:0]       b_wide;
	logic             w_in_range;
	logic             d_in_range;
	logic [IDX_W-1:0] w_addr;
	logic [IDX_W-1:0] d_addr;
	logic             ov_ok;
	logic             iv_ok;
	logic             itf_ok;
	logic             hit;
	res_t             res_d;

	assign w_wide     = 9'(req_q.entry_index);
	assign d_wide     = 9'(def_index_q);
	assign b_wide     = 9'(best_idx_q);
	assign w_in_range = (w_wide < 9'(ENTRIES));
	assign d_in_range = (d_wide < 9'(ENTRIES));
	assign w_addr     = w_wide[IDX_W-1:0];
	assign d_addr     = d_wide[IDX_W-1:0];

	assign sts.last = (cnt_q == IDX_W'(ENTRIES - 1));

	// request and scan control
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// rule table
	always_ff @(posedge clk) begin
		if (cmd.write && w_in_range && req_q.entry_valid) begin
			mem_q[w_addr] <= '{ov: req_q.outer_vlan, om: req_q.outer_mask,
				iv: req_q.inner_vlan, im: req_q.inner_mask,
				en: req_q.entry_enabled, prio: req_q.priority_req,
				itf: req_q.interface_req};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rule_s1 <= mem_q[cnt_q];
			vld_s1  <= valid_q[cnt_q];
			idx_s1  <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.write && w_in_range) begin
			valid_q[w_addr] <= req_q.entry_valid;
		end
	end

	// match and priority compare
	assign ov_ok  = (rule_s1.ov == 16'h0) ||
		((req_q.outer_vlan & rule_s1.om) == (rule_s1.ov & rule_s1.om));
	assign iv_ok  = (rule_s1.iv == 16'h0) ||
		((req_q.inner_vlan & rule_s1.im) == (rule_s1.iv & rule_s1.im));
	assign itf_ok = (rule_s1.itf == 16'h0) || (rule_s1.itf == req_q.interface_req);
	assign hit    = rd_s1 && vld_s1 && rule_s1.en && ov_ok && iv_ok && itf_ok &&
		(rule_s1.prio < best_prio_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			best_prio_q <= PRIO_NONE;
			best_idx_q  <= '0;
		end else if (cmd.load) begin
			found_q     <= 1'b0;
			best_prio_q <= PRIO_NONE;
			best_idx_q  <= '0;
		end else if (hit) begin
			found_q     <= 1'b1;
			best_prio_q <= rule_s1.prio;
			best_idx_q  <= idx_s1;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_valid_q <= 1'b0;
			def_index_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEFAULT_VALID: def_valid_q <= cfg_wdata[0];
				CFG_DEFAULT_INDEX: def_index_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// result with default fallback
	always_comb begin
		res_d = '0;
		if (req_q.opcode == OP_LOOKUP) begin
			if (found_q) begin
				res_d.found         = 1'b1;
				res_d.profile_index = b_wide[3:0];
			end else if (def_valid_q && d_in_range && valid_q[d_addr]) begin
				res_d.found         = 1'b1;
				res_d.profile_index = def_index_q;
				res_d.used_default  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== sv/vlan_priority_profile_classifier_core.sv =====
// Write request: busy in the write state, result strobed on done in the cycle after.
// Lookup request: scans one rule a cycle from the rule memory, busy through the scan,
// final and output states; done is registered from the output state.
// A new request is taken in the done cycle, never while busy. done is a single-cycle
// strobe; the receiver cannot stall it.
// Async reset clears state, config and all rule valid bits; no clearing pass.
`default_nettype none
module vlan_priority_profile_classifier_core import vppc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire req_t                  req,
	output logic                       done,
	output res_t                       res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	vppc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	vppc_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.res       (res)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_default_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.used_default |-> res.found)
		else $error("default used without found");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.found |-> res.profile_index == 4'h0)
		else $error("non-zero index on miss");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.opcode == OP_WRITE |=> ##1 done && !res.found)
		else $error("write request result wrong");

endmodule
`default_nettype wire
